// ----- rtl/sasv_pkg.sv -----
package sasv_pkg;

  // width of the two configuration registers
  localparam int REG_W = 23;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [REG_W-1:0] ARRIVAL_RADIUS_RST = 23'd25600;
  localparam logic [REG_W-1:0] MAX_SPEED_RST      = 23'd153600;

  typedef enum logic {
    REG_ARRIVAL_RADIUS = 1'b0,
    REG_MAX_SPEED      = 1'b1
  } reg_idx_t;

  // pipeline control shared by the arithmetic units
  typedef struct packed {
    logic adv;
    logic vld;
  } stage_ctl_t;

endpackage

// ----- rtl/sasv_sqrt.sv -----
module sasv_sqrt #(
  parameter int IW    = 52,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sasv_pkg::stage_ctl_t             ctl,
  input  logic [LANES-1:0][IW-1:0]         rad,
  input  logic [PW-1:0]                    tag_in,
  output logic                             vld_out,
  output logic [LANES-1:0][IW/2-1:0]       root_out,
  output logic [PW-1:0]                    tag_out
);

  localparam int RW = IW / 2;

  logic [RW-1:0]                 vld;
  logic [LANES-1:0][RW+1:0]      rem       [RW];
  logic [LANES-1:0][RW-1:0]      root      [RW];
  logic [LANES-1:0][IW-1:0]      src       [RW];
  logic [PW-1:0]                 tag       [RW];
  logic [LANES-1:0][RW+1:0]      rem_in    [RW];
  logic [LANES-1:0][RW-1:0]      root_in   [RW];
  logic [LANES-1:0][IW-1:0]      src_in    [RW];
  logic [LANES-1:0][RW+1:0]      rem_next  [RW];
  logic [LANES-1:0][RW-1:0]      root_next [RW];
  logic [LANES-1:0][IW-1:0]      src_next  [RW];

  // one result bit per stage, two radicand bits brought down each time
  always_comb begin
    logic [RW+1:0] pre;
    logic [RW+1:0] trial;
    rem_in[0]  = '0;
    root_in[0] = '0;
    src_in[0]  = rad;
    for (int k = 1; k < RW; k++) begin
      rem_in[k]  = rem[k-1];
      root_in[k] = root[k-1];
      src_in[k]  = src[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        pre   = {rem_in[k][l][RW-1:0], src_in[k][l][IW-1:IW-2]};
        trial = {root_in[k][l], 2'b01};
        if (pre >= trial) begin
          rem_next[k][l]  = pre - trial;
          root_next[k][l] = {root_in[k][l][RW-2:0], 1'b1};
        end else begin
          rem_next[k][l]  = pre;
          root_next[k][l] = {root_in[k][l][RW-2:0], 1'b0};
        end
        src_next[k][l] = {src_in[k][l][IW-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.adv) begin
      vld <= {vld[RW-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < RW; k++) begin
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
        src[k]  <= src_next[k];
      end
      tag[0] <= tag_in;
      for (int k = 1; k < RW; k++) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  assign vld_out  = vld[RW-1];
  assign root_out = root[RW-1];
  assign tag_out  = tag[RW-1];

endmodule

// ----- rtl/sasv_div.sv -----
module sasv_div #(
  parameter int NW    = 48,
  parameter int DW    = 26,
  parameter int QW    = 23,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sasv_pkg::stage_ctl_t         ctl,
  input  logic [LANES-1:0][NW-1:0]     num,
  input  logic [DW-1:0]                den,
  input  logic [PW-1:0]                tag_in,
  output logic                         vld_out,
  output logic [LANES-1:0][QW-1:0]     quo_out,
  output logic [PW-1:0]                tag_out
);

  // the quotient must fit in QW bits: num < den << QW

  logic [QW-1:0]                 vld;
  logic [LANES-1:0][DW-1:0]      rem       [QW];
  logic [LANES-1:0][QW-1:0]      low       [QW];
  logic [DW-1:0]                 dens      [QW];
  logic [PW-1:0]                 tag       [QW];
  logic [LANES-1:0][DW-1:0]      rem_in    [QW];
  logic [LANES-1:0][QW-1:0]      low_in    [QW];
  logic [DW-1:0]                 den_in    [QW];
  logic [LANES-1:0][DW-1:0]      rem_next  [QW];
  logic [LANES-1:0][QW-1:0]      low_next  [QW];

  // restoring division, quotient bits shift in where numerator bits leave
  always_comb begin
    logic [DW:0] pre;
    logic        ge;
    for (int l = 0; l < LANES; l++) begin
      rem_in[0][l] = DW'(num[l] >> QW);
      low_in[0][l] = num[l][QW-1:0];
    end
    den_in[0] = den;
    for (int k = 1; k < QW; k++) begin
      rem_in[k] = rem[k-1];
      low_in[k] = low[k-1];
      den_in[k] = dens[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        pre = {rem_in[k][l], low_in[k][l][QW-1]};
        ge  = pre >= {1'b0, den_in[k]};
        if (ge) begin
          rem_next[k][l] = DW'(pre - {1'b0, den_in[k]});
        end else begin
          rem_next[k][l] = pre[DW-1:0];
        end
        low_next[k][l] = {low_in[k][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.adv) begin
      vld <= {vld[QW-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < QW; k++) begin
        rem[k]  <= rem_next[k];
        low[k]  <= low_next[k];
        dens[k] <= den_in[k];
      end
      tag[0] <= tag_in;
      for (int k = 1; k < QW; k++) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  assign vld_out = vld[QW-1];
  assign quo_out = low[QW-1];
  assign tag_out = tag[QW-1];

endmodule

// ----- rtl/seek_arrive_steering_vector.sv -----
// Seek/arrive steering unit. Each request beat carries target, position and velocity
// (signed fixed point, COORD_WIDTH bits) and yields one steering force beat. The block
// is fully pipelined: one beat enters per clock while the pipeline is not stalled. Its
// depth is set by the three 23-step pipelined dividers (arrive speed, normalize,
// limit) and the two digit-by-digit square root pipelines (distance and |u|, then the
// length of the force). A stall on the response side freezes the whole pipeline; the
// output register holds the waiting beat. The user must write the registers over the
// APB port only while no beat is in flight; the block itself does not enforce this.
module seek_arrive_steering_vector #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sasv_pkg::APB_AW-1:0]          paddr,
  input  logic [sasv_pkg::APB_DW-1:0]          pwdata,
  output logic [sasv_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic                                 cmd,
  input  logic signed [COORD_WIDTH-1:0]        target_x,
  input  logic signed [COORD_WIDTH-1:0]        target_y,
  input  logic signed [COORD_WIDTH-1:0]        target_z,
  input  logic signed [COORD_WIDTH-1:0]        pos_x,
  input  logic signed [COORD_WIDTH-1:0]        pos_y,
  input  logic signed [COORD_WIDTH-1:0]        pos_z,
  input  logic signed [COORD_WIDTH-1:0]        vel_x,
  input  logic signed [COORD_WIDTH-1:0]        vel_y,
  input  logic signed [COORD_WIDTH-1:0]        vel_z,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic signed [COORD_WIDTH-1:0]        force_x,
  output logic signed [COORD_WIDTH-1:0]        force_y,
  output logic signed [COORD_WIDTH-1:0]        force_z,
  output logic                                 used_arrive
);

  localparam int C     = COORD_WIDTH;
  localparam int REG_W = sasv_pkg::REG_W;
  localparam int MG    = C + 1;
  localparam int SQ_W  = 2 * C + 4;
  localparam int RT_W  = SQ_W / 2;
  localparam int SC_W  = (SQ_W > 2 * REG_W) ? SQ_W : 2 * REG_W;
  localparam int MW    = (C > REG_W) ? C : REG_W;
  localparam int FW    = MW + 2;
  localparam int FM    = MW + 1;
  localparam int V_W   = 2 * FM + 2;
  localparam int VR_W  = V_W / 2;
  localparam int N1_W  = REG_W + RT_W;
  localparam int N2_W  = MG + REG_W;
  localparam int N3_W  = FM + REG_W;

  localparam logic signed [FM:0] OUT_MAX = {{(FM + 2 - C){1'b0}}, {(C - 1){1'b1}}};
  localparam logic signed [FM:0] OUT_MIN = ~OUT_MAX;

  typedef struct packed {
    logic                  cmd;
    logic [SQ_W-1:0]       s2;
    logic [2:0][MG-1:0]    dm;
    logic [2:0]            ds;
    logic [2:0][MG-1:0]    um;
    logic [2:0]            us;
    logic [2:0][C-1:0]     vel;
  } tag_a_t;

  typedef struct packed {
    logic                  arrive;
    logic [RT_W-1:0]       len_d;
    logic [RT_W-1:0]       len_u;
    logic [2:0][MG-1:0]    dm;
    logic [2:0]            ds;
    logic [2:0][MG-1:0]    um;
    logic [2:0]            us;
    logic [2:0][C-1:0]     vel;
  } tag_b_t;

  typedef struct packed {
    logic                  arrive;
    logic                  den_zero;
    logic [2:0]            sg;
    logic [2:0][C-1:0]     vel;
  } tag_c_t;

  typedef struct packed {
    logic                  arrive;
    logic [V_W-1:0]        v2;
    logic [2:0][FM-1:0]    fm;
    logic [2:0]            fs;
  } tag_d_t;

  typedef struct packed {
    logic                  arrive;
    logic                  over;
    logic [2:0][FM-1:0]    fm;
    logic [2:0]            fs;
  } tag_e_t;

  // configuration
  logic [REG_W-1:0]   radius;
  logic [REG_W-1:0]   max_spd;
  logic [2*REG_W-1:0] rsq;
  logic [2*REG_W-1:0] mssq;
  sasv_pkg::reg_idx_t reg_idx;

  assign reg_idx = sasv_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= sasv_pkg::ARRIVAL_RADIUS_RST;
      max_spd <= sasv_pkg::MAX_SPEED_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        sasv_pkg::REG_ARRIVAL_RADIUS: radius  <= pwdata[REG_W-1:0];
        sasv_pkg::REG_MAX_SPEED:      max_spd <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sasv_pkg::REG_ARRIVAL_RADIUS: prdata = sasv_pkg::APB_DW'(radius);
      sasv_pkg::REG_MAX_SPEED:      prdata = sasv_pkg::APB_DW'(max_spd);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rsq  <= radius * radius;
    mssq <= max_spd * max_spd;
  end

  // pipeline advance: everything moves unless the output beat is held
  logic adv;
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  logic [2:0][C-1:0] tgt, pos, vin;
  assign tgt = {target_z, target_y, target_x};
  assign pos = {pos_z, pos_y, pos_x};
  assign vin = {vel_z, vel_y, vel_x};

  // stage 1: differences
  logic                v1, cmd1;
  logic [2:0][C:0]     d1;
  logic [2:0][C+1:0]   u1;
  logic [2:0][C-1:0]   vel1;
  logic [2:0][C:0]     d_c;
  logic [2:0][C+1:0]   u_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = (C+1)'($signed(tgt[i])) - (C+1)'($signed(pos[i]));
      u_c[i] = (C+2)'($signed(d_c[i])) - (C+2)'($signed(vin[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= cmd;
      d1   <= d_c;
      u1   <= u_c;
      vel1 <= vin;
    end
  end

  // stage 2: magnitudes and squares
  logic                   v2, cmd2;
  logic [2:0][MG-1:0]     dm2, um2;
  logic [2:0]             ds2, us2;
  logic [2:0][C-1:0]      vel2;
  logic [2:0][2*MG-1:0]   dsq2, usq2;
  logic [2:0][MG-1:0]     dm_c, um_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm_c[i] = d1[i][C] ? MG'(-$signed(d1[i])) : d1[i];
      um_c[i] = u1[i][C+1] ? MG'(-$signed(u1[i])) : MG'(u1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2 <= cmd1;
      vel2 <= vel1;
      dm2  <= dm_c;
      um2  <= um_c;
      for (int i = 0; i < 3; i++) begin
        ds2[i]  <= d1[i][C];
        us2[i]  <= u1[i][C+1];
        dsq2[i] <= dm_c[i] * dm_c[i];
        usq2[i] <= um_c[i] * um_c[i];
      end
    end
  end

  // stage 3: squared lengths, into the first root pipeline
  logic                   v3;
  logic [1:0][SQ_W-1:0]   rad_a;
  tag_a_t                 tag_a_in, tag_a_out;
  logic                   va;
  logic [1:0][RT_W-1:0]   root_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_a[0] <= SQ_W'(dsq2[0]) + SQ_W'(dsq2[1]) + SQ_W'(dsq2[2]);
      rad_a[1] <= SQ_W'(usq2[0]) + SQ_W'(usq2[1]) + SQ_W'(usq2[2]);
      tag_a_in.cmd <= cmd2;
      tag_a_in.s2  <= SQ_W'(dsq2[0]) + SQ_W'(dsq2[1]) + SQ_W'(dsq2[2]);
      tag_a_in.dm  <= dm2;
      tag_a_in.ds  <= ds2;
      tag_a_in.um  <= um2;
      tag_a_in.us  <= us2;
      tag_a_in.vel <= vel2;
    end
  end

  sasv_sqrt #(
    .IW(SQ_W), .LANES(2), .PW($bits(tag_a_t))
  ) u_sqrt_a (
    .clk(clk), .rst(rst),
    .ctl('{adv: adv, vld: v3}),
    .rad(rad_a), .tag_in(tag_a_in),
    .vld_out(va), .root_out(root_a), .tag_out(tag_a_out)
  );

  // stage 4: arrive decision, speed numerator
  logic                    v4;
  logic [0:0][N1_W-1:0]    num1;
  tag_b_t                  tag_b_in, tag_b_out;
  logic                    arrive_c;
  logic [N1_W-1:0]         num1_c;
  logic                    vb;
  logic [0:0][REG_W-1:0]   quo1;

  always_comb begin
    arrive_c = !tag_a_out.cmd && (SC_W'(tag_a_out.s2) <= SC_W'(rsq));
    num1_c   = '0;
    if (arrive_c && radius != '0) begin
      num1_c = max_spd * root_a[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1[0]         <= num1_c;
      tag_b_in.arrive <= arrive_c;
      tag_b_in.len_d  <= root_a[0];
      tag_b_in.len_u  <= root_a[1];
      tag_b_in.dm     <= tag_a_out.dm;
      tag_b_in.ds     <= tag_a_out.ds;
      tag_b_in.um     <= tag_a_out.um;
      tag_b_in.us     <= tag_a_out.us;
      tag_b_in.vel    <= tag_a_out.vel;
    end
  end

  sasv_div #(
    .NW(N1_W), .DW(REG_W), .QW(REG_W), .LANES(1), .PW($bits(tag_b_t))
  ) u_div_speed (
    .clk(clk), .rst(rst),
    .ctl('{adv: adv, vld: v4}),
    .num(num1), .den(radius), .tag_in(tag_b_in),
    .vld_out(vb), .quo_out(quo1), .tag_out(tag_b_out)
  );

  // stage 5: normalize numerators, arrive uses u at the slowed speed
  logic                    v5;
  logic [2:0][N2_W-1:0]    num2;
  logic [RT_W-1:0]         den2;
  tag_c_t                  tag_c_in, tag_c_out;
  logic [REG_W-1:0]        speed_c;
  logic [REG_W-1:0]        mul_b;
  logic [2:0][MG-1:0]      mul_a;
  logic [RT_W-1:0]         den_c;
  logic                    vc;
  logic [2:0][REG_W-1:0]   quo2;

  always_comb begin
    speed_c = (radius == '0) ? max_spd : quo1[0];
    mul_b   = tag_b_out.arrive ? speed_c : max_spd;
    den_c   = tag_b_out.arrive ? tag_b_out.len_u : tag_b_out.len_d;
    for (int i = 0; i < 3; i++) begin
      mul_a[i] = tag_b_out.arrive ? tag_b_out.um[i] : tag_b_out.dm[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num2[i] <= mul_a[i] * mul_b;
      end
      den2              <= den_c;
      tag_c_in.arrive   <= tag_b_out.arrive;
      tag_c_in.den_zero <= den_c == '0;
      tag_c_in.sg       <= tag_b_out.arrive ? tag_b_out.us : tag_b_out.ds;
      tag_c_in.vel      <= tag_b_out.vel;
    end
  end

  sasv_div #(
    .NW(N2_W), .DW(RT_W), .QW(REG_W), .LANES(3), .PW($bits(tag_c_t))
  ) u_div_norm (
    .clk(clk), .rst(rst),
    .ctl('{adv: adv, vld: v5}),
    .num(num2), .den(den2), .tag_in(tag_c_in),
    .vld_out(vc), .quo_out(quo2), .tag_out(tag_c_out)
  );

  // stage 6: signed force before the limit, seek subtracts velocity here
  logic                   v6, arr6;
  logic [2:0][FW-1:0]     f6;
  logic [2:0][FW-1:0]     f_c;

  always_comb begin
    logic signed [FW-1:0] wv;
    logic signed [FW-1:0] vv;
    for (int i = 0; i < 3; i++) begin
      wv = tag_c_out.den_zero ? '0 : $signed(FW'(quo2[i]));
      if (tag_c_out.sg[i]) begin
        wv = -wv;
      end
      vv = tag_c_out.arrive ? '0 : FW'($signed(tag_c_out.vel[i]));
      f_c[i] = wv - vv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f6   <= f_c;
      arr6 <= tag_c_out.arrive;
    end
  end

  // stage 7: magnitudes and squares of the force
  logic                   v7, arr7;
  logic [2:0][FM-1:0]     fm7;
  logic [2:0]             fs7;
  logic [2:0][2*FM-1:0]   fsq7;
  logic [2:0][FM-1:0]     fm_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fm_c[i] = f6[i][FW-1] ? FM'(-$signed(f6[i])) : FM'(f6[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arr7 <= arr6;
      fm7  <= fm_c;
      for (int i = 0; i < 3; i++) begin
        fs7[i]  <= f6[i][FW-1];
        fsq7[i] <= fm_c[i] * fm_c[i];
      end
    end
  end

  // stage 8: squared force length, into the second root pipeline
  logic                   v8;
  logic [0:0][V_W-1:0]    rad_b;
  tag_d_t                 tag_d_in, tag_d_out;
  logic                   vd;
  logic [0:0][VR_W-1:0]   root_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_b[0]        <= V_W'(fsq7[0]) + V_W'(fsq7[1]) + V_W'(fsq7[2]);
      tag_d_in.v2     <= V_W'(fsq7[0]) + V_W'(fsq7[1]) + V_W'(fsq7[2]);
      tag_d_in.arrive <= arr7;
      tag_d_in.fm     <= fm7;
      tag_d_in.fs     <= fs7;
    end
  end

  sasv_sqrt #(
    .IW(V_W), .LANES(1), .PW($bits(tag_d_t))
  ) u_sqrt_b (
    .clk(clk), .rst(rst),
    .ctl('{adv: adv, vld: v8}),
    .rad(rad_b), .tag_in(tag_d_in),
    .vld_out(vd), .root_out(root_b), .tag_out(tag_d_out)
  );

  // stage 9: limit numerators
  logic                   v9;
  logic [2:0][N3_W-1:0]   num3;
  logic [VR_W-1:0]        den3;
  tag_e_t                 tag_e_in, tag_e_out;
  logic                   over_c;
  logic                   ve;
  logic [2:0][REG_W-1:0]  quo3;

  assign over_c = tag_d_out.v2 > V_W'(mssq);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num3[i] <= over_c ? N3_W'(tag_d_out.fm[i] * max_spd) : '0;
      end
      den3            <= root_b[0];
      tag_e_in.arrive <= tag_d_out.arrive;
      tag_e_in.over   <= over_c;
      tag_e_in.fm     <= tag_d_out.fm;
      tag_e_in.fs     <= tag_d_out.fs;
    end
  end

  sasv_div #(
    .NW(N3_W), .DW(VR_W), .QW(REG_W), .LANES(3), .PW($bits(tag_e_t))
  ) u_div_limit (
    .clk(clk), .rst(rst),
    .ctl('{adv: adv, vld: v9}),
    .num(num3), .den(den3), .tag_in(tag_e_in),
    .vld_out(ve), .quo_out(quo3), .tag_out(tag_e_out)
  );

  // output register: sign, saturate
  logic [2:0][C-1:0] out_c;

  always_comb begin
    logic [FM-1:0]      mag;
    logic signed [FM:0] sv;
    for (int i = 0; i < 3; i++) begin
      mag = tag_e_out.over ? FM'(quo3[i]) : tag_e_out.fm[i];
      sv  = $signed({1'b0, mag});
      if (tag_e_out.fs[i]) begin
        sv = -sv;
      end
      if (sv > OUT_MAX) begin
        sv = OUT_MAX;
      end else if (sv < OUT_MIN) begin
        sv = OUT_MIN;
      end
      out_c[i] = sv[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      force_x     <= $signed(out_c[0]);
      force_y     <= $signed(out_c[1]);
      force_z     <= $signed(out_c[2]);
      used_arrive <= tag_e_out.arrive;
    end
  end

  // valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      v1        <= req_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= va;
      v5        <= vb;
      v6        <= vc;
      v7        <= v6;
      v8        <= v7;
      v9        <= vd;
      rsp_valid <= ve;
    end
  end

endmodule
